FILE: src/nbf_pkg.sv
// ---------------------------------------------------------------------------
// nbf_pkg
// Shared types and constants of the nested box filter.
// ---------------------------------------------------------------------------
package nbf_pkg;

    // coordinate and size widths
    localparam int COORD_W = 12;
    localparam int SIZE_W  = COORD_W + 1;

    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

    // default box store depth
    localparam int MAX_CONTOURS_DEF = 16;

    // stream payload widths (whole bytes)
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;

    // one bounding box, corners inclusive
    typedef struct packed {
        logic [COORD_W-1:0] hi_y;
        logic [COORD_W-1:0] hi_x;
        logic [COORD_W-1:0] lo_y;
        logic [COORD_W-1:0] lo_x;
    } t_box;

endpackage

FILE: src/nested_box_filter.sv
// ---------------------------------------------------------------------------
// nested_box_filter
// Collects contour bounding boxes, drops boxes nested in another box and
// streams out the kept boxes with their centers.
// ---------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                           | tlast       | tuser
//  s       | in  | point_x[11:0], point_y[23:12]                | contour_end | set_end
//  m       | out | box_left, box_top, box_width, box_height,    | last_box    | dropped
//          |     | mid_x, mid_y (bits 75:0, zero pad)           |             |
//
//  Points: one per cycle while collecting.
//  After set_end the pairwise pass over N stored boxes runs on one shared
//  comparator, reading the box store once per cycle.
//  Emission: kept boxes pass S_ERD, S_EFMT, S_EOUT; rejected ones only S_ERD.
//  o_s_tready is low from set_end until the last box transaction completes.
//  Reset is synchronous; the box store needs no clearing pass.
// ---------------------------------------------------------------------------
module nested_box_filter #(
    parameter int MAX_CONTOURS = nbf_pkg::MAX_CONTOURS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // point stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [nbf_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // point_x, point_y
    input  logic                            i_s_tlast,  // contour_end
    input  logic                            i_s_tuser,  // set_end
    // box stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [nbf_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // left, top, width, height,
                                                        // mid_x, mid_y
    output logic                            o_m_tlast,  // last_box
    output logic                            o_m_tuser   // dropped
);

    localparam int IDX_W = $clog2(MAX_CONTOURS);
    localparam int CNT_W = $clog2(MAX_CONTOURS + 1);
    localparam int CW    = nbf_pkg::COORD_W;
    localparam int SW    = nbf_pkg::SIZE_W;
    localparam int PAD_W = nbf_pkg::OUT_TDATA_W - 2 * CW - 4 * SW;

    typedef enum logic [2:0] {
        S_ACC,    // collecting points
        S_RD_I,   // fetch box i
        S_CAP,    // latch box i, fetch box 0
        S_CMP,    // compare box i with box j
        S_ERD,    // fetch next kept box
        S_EFMT,   // format result
        S_EOUT    // hold result until taken
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    logic                    r_overflow;
    logic [IDX_W-1:0]        r_i;
    logic [IDX_W-1:0]        r_j;
    logic [IDX_W-1:0]        r_last;
    logic                    r_keep_cur;
    logic [MAX_CONTOURS-1:0] r_keep;
    nbf_pkg::t_box           r_box_i;
    nbf_pkg::t_box           r_rd_data;
    nbf_pkg::t_box           r_mem [MAX_CONTOURS];

    logic                    w_accept;
    logic                    w_close;
    logic                    w_store;
    logic [CNT_W-1:0]        n_count;
    logic [IDX_W-1:0]        w_rd_addr;
    logic [CNT_W-1:0]        w_count_m1;
    logic                    w_nested;
    logic                    w_keep_now;
    nbf_pkg::t_box           w_run_box;
    logic [SW-1:0]           w_width;
    logic [SW-1:0]           w_height;

    assign o_s_tready = (r_state == S_ACC);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_close    = i_s_tlast || i_s_tuser;
    assign w_store    = w_accept && w_close && (r_count < CNT_W'(MAX_CONTOURS));
    assign n_count    = w_store ? r_count + CNT_W'(1) : r_count;
    assign w_count_m1 = r_count - CNT_W'(1);

    // running box of the open contour
    nbf_run_box u_run_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_x     (i_s_tdata[CW-1:0]),
        .i_y     (i_s_tdata[2*CW-1:CW]),
        .i_close (w_close),
        .o_box   (w_run_box)
    );

    // shared nesting comparator
    nbf_nest_cmp u_nest_cmp (
        .i_a      (r_box_i),
        .i_b      (r_rd_data),
        .o_nested (w_nested)
    );

    assign w_keep_now = r_keep_cur && !(w_nested && (r_j != r_i));

    // box store read address
    always_comb begin
        unique case (r_state)
            S_CAP:   w_rd_addr = '0;
            S_CMP:   w_rd_addr = r_j + IDX_W'(1);
            default: w_rd_addr = r_i;
        endcase
    end

    // box store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[IDX_W-1:0]] <= w_run_box;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // size of the fetched box
    assign w_width  = {1'b0, r_rd_data.hi_x} - {1'b0, r_rd_data.lo_x} + SW'(1);
    assign w_height = {1'b0, r_rd_data.hi_y} - {1'b0, r_rd_data.lo_y} + SW'(1);

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_ACC;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_last     <= '0;
            r_keep_cur <= 1'b0;
            r_keep     <= '0;
            o_m_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_ACC: begin
                    if (w_accept) begin
                        r_count <= n_count;
                        if (w_close && !w_store) begin
                            r_overflow <= 1'b1;
                        end
                        if (i_s_tuser) begin
                            r_i    <= '0;
                            r_last <= '0;
                            if (n_count == '0) begin
                                r_overflow <= 1'b0;
                            end else begin
                                r_state <= S_RD_I;
                            end
                        end
                    end
                end
                S_RD_I: begin
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    r_box_i    <= r_rd_data;
                    r_j        <= '0;
                    r_keep_cur <= 1'b1;
                    r_state    <= S_CMP;
                end
                S_CMP: begin
                    if (CNT_W'(r_j) == w_count_m1) begin
                        r_keep[r_i] <= w_keep_now;
                        if (w_keep_now) begin
                            r_last <= r_i;
                        end
                        if (CNT_W'(r_i) == w_count_m1) begin
                            r_i     <= '0;
                            r_state <= S_ERD;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_RD_I;
                        end
                    end else begin
                        r_keep_cur <= w_keep_now;
                        r_j        <= r_j + IDX_W'(1);
                    end
                end
                S_ERD: begin
                    // skip rejected boxes; the last kept index bounds the walk
                    if (r_keep[r_i]) begin
                        r_state <= S_EFMT;
                    end else begin
                        r_i <= r_i + IDX_W'(1);
                    end
                end
                S_EFMT: begin
                    o_m_tdata <= {PAD_W'(0),
                                  SW'(r_rd_data.lo_y) + (w_height >> 1),
                                  SW'(r_rd_data.lo_x) + (w_width >> 1),
                                  w_height, w_width,
                                  r_rd_data.lo_y, r_rd_data.lo_x};
                    o_m_tlast  <= (r_i == r_last);
                    o_m_tuser  <= r_overflow;
                    o_m_tvalid <= 1'b1;
                    r_state    <= S_EOUT;
                end
                S_EOUT: begin
                    if (i_m_tready) begin
                        o_m_tvalid <= 1'b0;
                        if (r_i == r_last) begin
                            r_count    <= '0;
                            r_overflow <= 1'b0;
                            r_state    <= S_ACC;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CONTOURS))
        else $error("box count above store depth");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == CNT_W'(MAX_CONTOURS)))
        else $error("overflow flagged with free store entries");

    a_no_out_while_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> !o_m_tvalid)
        else $error("result shown while collecting points");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast)
            |=> (o_s_tready && (r_count == '0) && !r_overflow))
        else $error("set state not cleared after last box");

endmodule

FILE: src/nbf_run_box.sv
// ---------------------------------------------------------------------------
// nbf_run_box
// Running bounding box of the current contour; cleared when it closes.
// ---------------------------------------------------------------------------
module nbf_run_box (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,   // a point transaction this cycle
    input  logic [nbf_pkg::COORD_W-1:0] i_x,
    input  logic [nbf_pkg::COORD_W-1:0] i_y,
    input  logic                        i_close,   // contour closes with this point
    output nbf_pkg::t_box               o_box      // box with this point folded in
);

    nbf_pkg::t_box r_box;
    nbf_pkg::t_box n_box;

    // fold the incoming point into the held extremes
    always_comb begin
        n_box.lo_x = (i_x < r_box.lo_x) ? i_x : r_box.lo_x;
        n_box.lo_y = (i_y < r_box.lo_y) ? i_y : r_box.lo_y;
        n_box.hi_x = (i_x > r_box.hi_x) ? i_x : r_box.hi_x;
        n_box.hi_y = (i_y > r_box.hi_y) ? i_y : r_box.hi_y;
    end

    assign o_box = n_box;

    // hold, update, or restart on contour close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_close)) begin
            r_box.lo_x <= nbf_pkg::COORD_MAX;
            r_box.lo_y <= nbf_pkg::COORD_MAX;
            r_box.hi_x <= '0;
            r_box.hi_y <= '0;
        end else if (i_valid) begin
            r_box <= n_box;
        end
    end

endmodule

FILE: src/nbf_nest_cmp.sv
// ---------------------------------------------------------------------------
// nbf_nest_cmp
// Nesting test: box a has a greater corner and a smaller size than box b.
// ---------------------------------------------------------------------------
module nbf_nest_cmp (
    input  nbf_pkg::t_box i_a,
    input  nbf_pkg::t_box i_b,
    output logic          o_nested
);

    logic [nbf_pkg::COORD_W-1:0] w_span_ax;
    logic [nbf_pkg::COORD_W-1:0] w_span_ay;
    logic [nbf_pkg::COORD_W-1:0] w_span_bx;
    logic [nbf_pkg::COORD_W-1:0] w_span_by;

    // spans are size minus one; hi never falls below lo
    assign w_span_ax = i_a.hi_x - i_a.lo_x;
    assign w_span_ay = i_a.hi_y - i_a.lo_y;
    assign w_span_bx = i_b.hi_x - i_b.lo_x;
    assign w_span_by = i_b.hi_y - i_b.lo_y;

    assign o_nested = (i_a.lo_x > i_b.lo_x) && (i_a.lo_y > i_b.lo_y)
                   && (w_span_ay < w_span_by) && (w_span_ax < w_span_bx);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for nested_box_filter. Streams contour points in sets,
// predicts the kept boxes of each set with an independent model of the
// bounding-box and nesting logic, and checks every box transaction field by
// field. A short directed table comes first, then random sets under three
// idle profiles, one long output hold-off and drain pauses.
// ---------------------------------------------------------------------------
module testbench;

    localparam int N_BOXES       = nbf_pkg::MAX_CONTOURS_DEF;
    localparam int CW            = nbf_pkg::COORD_W;
    localparam int SW            = nbf_pkg::SIZE_W;
    localparam int RANDOM_POINTS = 200;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;

    // one kept box as seen on the output stream
    typedef struct {
        logic [CW-1:0] left;
        logic [CW-1:0] top;
        logic [SW-1:0] width;
        logic [SW-1:0] height;
        logic [SW-1:0] mid_x;
        logic [SW-1:0] mid_y;
        logic          last_box;
        logic          dropped;
    } t_box_result;

    // one row of the directed point table
    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          contour_end;
        logic          set_end;
        bit            typed;
        t_box_result   want;
    } t_point_row;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic [nbf_pkg::IN_TDATA_W-1:0]  i_s_tdata  = '0;    // point_x, point_y
    logic                            i_s_tlast  = 1'b0;  // contour_end
    logic                            i_s_tuser  = 1'b0;  // set_end
    logic                            i_m_tready = 1'b0;
    logic                            o_s_tready;
    logic                            o_m_tvalid;
    logic [nbf_pkg::OUT_TDATA_W-1:0] o_m_tdata;          // left, top, width, height,
                                                         // mid_x, mid_y
    logic                            o_m_tlast;          // last_box
    logic                            o_m_tuser;          // dropped

    // box model state
    logic [CW-1:0]      run_lo_x, run_lo_y, run_hi_x, run_hi_y;
    nbf_pkg::t_box      held_boxes [N_BOXES];
    int                 held_count;
    bit                 lost_contours;

    t_box_result predicted_boxes [$];
    t_box_result expected_boxes [$];
    t_box_result typed_by_set [int];
    t_point_row  directed_rows [$];

    int errors;
    int points_sent;
    int sets_closed;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_armed;

    nested_box_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_run();
        run_lo_x = nbf_pkg::COORD_MAX;
        run_lo_y = nbf_pkg::COORD_MAX;
        run_hi_x = '0;
        run_hi_y = '0;
    endfunction

    // inner counts as nested in outer: greater corner, smaller size
    function automatic bit box_nested_in(nbf_pkg::t_box inner, nbf_pkg::t_box outer);
        int wi, hi, wo, ho;
        wi = int'(inner.hi_x) - int'(inner.lo_x) + 1;
        hi = int'(inner.hi_y) - int'(inner.lo_y) + 1;
        wo = int'(outer.hi_x) - int'(outer.lo_x) + 1;
        ho = int'(outer.hi_y) - int'(outer.lo_y) + 1;
        return inner.lo_x > outer.lo_x && inner.lo_y > outer.lo_y && wi < wo && hi < ho;
    endfunction

    // track one point; on set end, queue the kept boxes of the set
    function automatic void predict_point(logic [CW-1:0] px, logic [CW-1:0] py,
                                          logic ce, logic se);
        bit            keep [N_BOXES];
        int            last_kept;
        int            w, h;
        nbf_pkg::t_box b;
        t_box_result   r;
        if (px < run_lo_x) run_lo_x = px;
        if (py < run_lo_y) run_lo_y = py;
        if (px > run_hi_x) run_hi_x = px;
        if (py > run_hi_y) run_hi_y = py;

        // set end closes the open contour as well
        if (ce || se) begin
            if (held_count < N_BOXES) begin
                b.lo_x = run_lo_x;
                b.lo_y = run_lo_y;
                b.hi_x = run_hi_x;
                b.hi_y = run_hi_y;
                held_boxes[held_count] = b;
                held_count++;
            end else begin
                lost_contours = 1'b1;
            end
            clear_run();
        end
        if (!se) return;

        // pairwise nesting pass
        last_kept = 0;
        for (int i = 0; i < held_count; i++) begin
            keep[i] = 1'b1;
            for (int j = 0; j < held_count; j++)
                if (i != j && box_nested_in(held_boxes[i], held_boxes[j])) keep[i] = 1'b0;
            if (keep[i]) last_kept = i;
        end

        for (int i = 0; i < held_count; i++) begin
            if (keep[i]) begin
                b = held_boxes[i];
                w = int'(b.hi_x) - int'(b.lo_x) + 1;
                h = int'(b.hi_y) - int'(b.lo_y) + 1;
                r.left     = b.lo_x;
                r.top      = b.lo_y;
                r.width    = SW'(w);
                r.height   = SW'(h);
                r.mid_x    = SW'(int'(b.lo_x) + w / 2);
                r.mid_y    = SW'(int'(b.lo_y) + h / 2);
                r.last_box = (i == last_kept);
                r.dropped  = lost_contours;
                predicted_boxes.insert(predicted_boxes.size(), r);
            end
        end
        held_count    = 0;
        lost_contours = 1'b0;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // input side: every accepted point goes through the model
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            predict_point(i_s_tdata[11:0], i_s_tdata[23:12], i_s_tlast, i_s_tuser);
            if (i_s_tuser) begin
                if (typed_by_set.exists(sets_closed))
                    expected_boxes.insert(expected_boxes.size(),
                                          typed_by_set[sets_closed]);
                else
                    foreach (predicted_boxes[k])
                        expected_boxes.insert(expected_boxes.size(), predicted_boxes[k]);
                predicted_boxes.delete();
                sets_closed++;
            end
        end
    end

    // output side: compare each box transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_box_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_boxes.size() == 0) begin
                $error("box transaction with none expected: left %0d top %0d",
                       o_m_tdata[11:0], o_m_tdata[23:12]);
                errors++;
            end else begin
                want = expected_boxes.pop_front();
                check_field("box_left",   want.left,     o_m_tdata[11:0]);
                check_field("box_top",    want.top,      o_m_tdata[23:12]);
                check_field("box_width",  want.width,    o_m_tdata[36:24]);
                check_field("box_height", want.height,   o_m_tdata[49:37]);
                check_field("mid_x",      want.mid_x,    o_m_tdata[62:50]);
                check_field("mid_y",      want.mid_y,    o_m_tdata[75:63]);
                check_field("last_box",   want.last_box, o_m_tlast);
                check_field("dropped",    want.dropped,  o_m_tuser);
            end
        end
    end

    // receiver: random stalls, or one long hold-off when armed
    always @(posedge i_clk) begin
        if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // offer one point and hold it until the transaction completes
    task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py,
                              logic ce, logic se);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {py, px};
        i_s_tlast  <= ce;
        i_s_tuser  <= se;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        points_sent++;
    endtask

    // stop offering until every expected box has arrived
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_boxes.size() != 0) @(posedge i_clk);
    endtask

    // one random set: mostly well-formed contours, some nested in the
    // previous one, a few stray points, sometimes more contours than fit
    task automatic send_random_set();
        int            n_contours, n_pts, size_x, size_y;
        bit            big, have_prev, last_contour, swap;
        logic [CW-1:0] lx, ly, hx, hy, plx, ply, phx, phy, px, py;
        logic          ce, se;
        big        = ($urandom_range(99) < 6);
        n_contours = big ? $urandom_range(19, 15) : $urandom_range(5, 1);
        have_prev  = 1'b0;
        plx = '0; ply = '0; phx = '0; phy = '0;
        for (int c = 0; c < n_contours; c++) begin
            if (have_prev && phx > plx && phy > ply && $urandom_range(99) < 40) begin
                // inside the previous box, sometimes sharing its left edge
                lx    = ($urandom_range(3) == 0) ? plx : CW'($urandom_range(phx, plx + 1));
                ly    = CW'($urandom_range(phy, ply + 1));
                hx    = CW'($urandom_range(phx, lx));
                hy    = CW'($urandom_range(phy, ly));
                n_pts = $urandom_range(4, 2);
            end else begin
                lx     = CW'($urandom_range(4095));
                ly     = CW'($urandom_range(4095));
                size_x = ($urandom_range(99) < 25) ? $urandom_range(4095) : $urandom_range(63);
                size_y = ($urandom_range(99) < 25) ? $urandom_range(4095) : $urandom_range(63);
                hx     = (int'(lx) + size_x > 4095) ? nbf_pkg::COORD_MAX
                                                    : CW'(int'(lx) + size_x);
                hy     = (int'(ly) + size_y > 4095) ? nbf_pkg::COORD_MAX
                                                    : CW'(int'(ly) + size_y);
                n_pts  = big ? $urandom_range(2, 1) : $urandom_range(4, 1);
            end
            plx = lx; ply = ly; phx = hx; phy = hy;
            have_prev    = 1'b1;
            last_contour = (c == n_contours - 1);
            swap         = ($urandom_range(1) == 1);
            for (int p = 0; p < n_pts; p++) begin
                if (n_pts == 1) begin
                    px = lx; py = ly;
                end else if (p == 0) begin
                    px = swap ? hx : lx; py = swap ? ly : hy;
                end else if (p == 1) begin
                    px = swap ? lx : hx; py = swap ? hy : ly;
                end else begin
                    px = CW'($urandom_range(hx, lx));
                    py = CW'($urandom_range(hy, ly));
                end
                // stray point
                if ($urandom_range(99) < 3) begin
                    px = CW'($urandom_range(4095));
                    py = CW'($urandom_range(4095));
                end
                // the final contour may end on set_end alone
                ce = (p == n_pts - 1) && (!last_contour || $urandom_range(3) != 0);
                se = last_contour && (p == n_pts - 1);
                send_point(px, py, ce, se);
            end
        end
    endtask

    // stimulus
    initial begin
        t_point_row r;
        int         set_index, base, done, phase, next_phase;
        errors        = 0;
        points_sent   = 0;
        sets_closed   = 0;
        hold_left     = 0;
        hold_armed    = 1'b0;
        held_count    = 0;
        lost_contours = 1'b0;
        clear_run();
        send_idle_pct = 14;
        recv_idle_pct = 72;

        // single point at the origin
        r = '{x: 12'd0, y: 12'd0, contour_end: 1'b1, set_end: 1'b1, typed: 1'b1,
              want: '{left: 12'd0, top: 12'd0, width: 13'd1, height: 13'd1,
                      mid_x: 13'd0, mid_y: 13'd0, last_box: 1'b1, dropped: 1'b0}};
        directed_rows.insert(directed_rows.size(), r);
        // full frame, closed by set_end without contour_end
        r = '{x: 12'd0, y: 12'd0, contour_end: 1'b0, set_end: 1'b0, typed: 1'b0,
              want: r.want};
        directed_rows.insert(directed_rows.size(), r);
        r = '{x: 12'd4095, y: 12'd4095, contour_end: 1'b0, set_end: 1'b1, typed: 1'b1,
              want: '{left: 12'd0, top: 12'd0, width: 13'd4096, height: 13'd4096,
                      mid_x: 13'd2048, mid_y: 13'd2048, last_box: 1'b1,
                      dropped: 1'b0}};
        directed_rows.insert(directed_rows.size(), r);
        // single point at the far corner
        r = '{x: 12'd4095, y: 12'd4095, contour_end: 1'b1, set_end: 1'b1, typed: 1'b1,
              want: '{left: 12'd4095, top: 12'd4095, width: 13'd1, height: 13'd1,
                      mid_x: 13'd4095, mid_y: 13'd4095, last_box: 1'b1,
                      dropped: 1'b0}};
        directed_rows.insert(directed_rows.size(), r);
        // outer box, a box nested in it, and a point on the outer left edge
        r.typed = 1'b0;
        r.x = 12'd10;  r.y = 12'd10;  r.contour_end = 1'b0; r.set_end = 1'b0;
        directed_rows.insert(directed_rows.size(), r);
        r.x = 12'd100; r.y = 12'd100; r.contour_end = 1'b1;
        directed_rows.insert(directed_rows.size(), r);
        r.x = 12'd20;  r.y = 12'd50;  r.contour_end = 1'b0;
        directed_rows.insert(directed_rows.size(), r);
        r.x = 12'd50;  r.y = 12'd20;  r.contour_end = 1'b1;
        directed_rows.insert(directed_rows.size(), r);
        r.x = 12'd10;  r.y = 12'd40;  r.set_end = 1'b1;
        directed_rows.insert(directed_rows.size(), r);
        // store full: one contour more than fits
        for (int k = 0; k <= N_BOXES; k++) begin
            r.x = CW'(k * 240 + 5);
            r.y = CW'(4090 - k * 240);
            r.contour_end = 1'b1;
            r.set_end     = (k == N_BOXES);
            directed_rows.insert(directed_rows.size(), r);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        set_index = 0;
        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            if (r.typed) typed_by_set[set_index] = r.want;
            if (r.set_end) set_index++;
            send_point(r.x, r.y, r.contour_end, r.set_end);
        end

        // random sets under the three idle profiles
        base  = points_sent;
        phase = 0;
        done  = 0;
        while (done < RANDOM_POINTS) begin
            next_phase = (done < RANDOM_POINTS / 3) ? 0 :
                         (done < 2 * RANDOM_POINTS / 3) ? 1 : 2;
            if (next_phase != phase) begin
                wait_drained();
                phase = next_phase;
                send_idle_pct = (phase == 1) ? 72 : 0;
                recv_idle_pct = (phase == 1) ? 14 : 0;
                // long output hold-off while points keep coming
                if (phase == 2) hold_armed = 1'b1;
            end
            send_random_set();
            done = points_sent - base;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_boxes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
